@@ rtl/core/gdte_pkg.sv @@
// Shared types and constants for the GPS date/time to epoch-milliseconds converter.
// Holds the item structs, reciprocal constants for the decimal unpacking and the month table.
// No dependencies.
`default_nettype none

package gdte_pkg;

    localparam int unsigned DATE_W = 20;
    localparam int unsigned TIME_W = 27;
    localparam int unsigned DEV_W  = 32;
    localparam int unsigned EPOCH_W = 42;

    typedef struct packed {
        logic [DATE_W-1:0] date_ddmmyy;
        logic [TIME_W-1:0] time_hhmmsscc;
        logic [DEV_W-1:0]  clock_deviation_ms;
    } t_in_item;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch_ms;
        logic               month_invalid;
    } t_out_item;

    // Reciprocal multipliers: floor(x / d) == (x * ceil(2^s / d)) >> s, with s = N + ceil(log2 d)
    localparam int unsigned    S_DATE_D100  = 27;
    localparam logic [63:0]    M_DATE_D100  = ((64'd1 << S_DATE_D100) + 64'd99) / 64'd100;
    localparam int unsigned    S_DATE_D1E4  = 34;
    localparam logic [63:0]    M_DATE_D1E4  = ((64'd1 << S_DATE_D1E4) + 64'd9999) / 64'd10000;
    localparam int unsigned    S_TIME_D100  = 34;
    localparam logic [63:0]    M_TIME_D100  = ((64'd1 << S_TIME_D100) + 64'd99) / 64'd100;
    localparam int unsigned    S_TIME_D1E4  = 41;
    localparam logic [63:0]    M_TIME_D1E4  = ((64'd1 << S_TIME_D1E4) + 64'd9999) / 64'd10000;
    localparam int unsigned    S_TIME_D1E6  = 47;
    localparam logic [63:0]    M_TIME_D1E6  = ((64'd1 << S_TIME_D1E6) + 64'd999999) / 64'd1000000;

    // Seconds from 1970-01-01 to 2000-01-01, less one day for the one-based day of month
    localparam logic [32:0]    SECS_BASE    = 33'd946684800 - 33'd86400;
    localparam logic [32:0]    SECS_PER_DAY = 33'd86400;
    localparam logic [41:0]    MS_PER_SEC   = 42'd1000;
    localparam logic [6:0]     MONTHS       = 7'd12;

    function automatic logic [8:0] days_before_month(input logic [6:0] mon);
        logic [8:0] d;
        case (mon)
            7'd1:    d = 9'd0;
            7'd2:    d = 9'd31;
            7'd3:    d = 9'd59;
            7'd4:    d = 9'd90;
            7'd5:    d = 9'd120;
            7'd6:    d = 9'd151;
            7'd7:    d = 9'd181;
            7'd8:    d = 9'd212;
            7'd9:    d = 9'd243;
            7'd10:   d = 9'd273;
            7'd11:   d = 9'd304;
            7'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gps_date_time_to_epoch_ms.sv @@
// Top level of the GPS date/time to Unix epoch-milliseconds converter.
// Depends on gdte_pkg for the item structs, reciprocal constants and month table.
//
// Usage:
//   Input channel (i_valid / o_ready / i_item) takes a decimal ddmmyy date, a decimal
//   hhmmsscc UTC time and a millisecond deviation. Output channel (o_valid / i_ready /
//   o_item) returns epoch milliseconds and a month-invalid flag, one result per item.
//   Each item moves through the stage registers in order, and o_valid rises when it
//   reaches the output register. Registers: input, decimal unpack, day count
//   and time-of-day seconds, total seconds, output. The unpack stage holds the reciprocal
//   multiplies and the multiply-subtract remainders; later stages hold a few multiplies
//   by constants plus adds.
//   Throughput is one item per cycle unless i_ready holds the output; every stage has
//   its own valid bit, so an empty stage keeps accepting while a finished result waits
//   at the output. When i_ready is low the output register holds its item and stages
//   behind it fill up one by one before o_ready drops.
//   Reset (synchronous, active low) clears all stage valid bits; payload registers
//   are not reset.
//   A month of 0 or above 12 gives epoch_ms of zero with month_invalid set.
`default_nettype none

module gps_date_time_to_epoch_ms (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire gdte_pkg::t_in_item  i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output gdte_pkg::t_out_item    o_item
);

    // stage valids
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 0: input register
    gdte_pkg::t_in_item r_in;

    // stage 1: unpacked fields
    logic [6:0]  r1_yy, r1_mon, r1_day, r1_min, r1_sec, r1_cc;
    logic [7:0]  r1_hour;
    logic [31:0] r1_dev;
    logic        r1_inv;
    logic [6:0]  n1_yy, n1_mon, n1_day, n1_min, n1_sec, n1_cc;
    logic [7:0]  n1_hour;
    logic [13:0] q_date_d100;
    logic [13:0] q_time_d1e4;
    logic [20:0] q_time_d100;

    // stage 2: day count and time-of-day seconds
    logic [16:0] r2_days;
    logic [18:0] r2_hms;
    logic [6:0]  r2_cc;
    logic [31:0] r2_dev;
    logic        r2_inv;
    logic [16:0] n2_days;
    logic [18:0] n2_hms;

    // stage 3: total seconds
    logic [32:0] r3_secs;
    logic [6:0]  r3_cc;
    logic [31:0] r3_dev;
    logic        r3_inv;
    logic [32:0] n3_secs;

    // stage 4: output register
    gdte_pkg::t_out_item r_out;
    gdte_pkg::t_out_item n_out;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = !r_v0 || rdy1;
    assign o_valid = r_v4;
    assign o_item  = r_out;

    always_comb begin
        q_date_d100 = 14'((64'(r_in.date_ddmmyy) * gdte_pkg::M_DATE_D100)
                          >> gdte_pkg::S_DATE_D100);
        n1_day      = 7'((64'(r_in.date_ddmmyy) * gdte_pkg::M_DATE_D1E4)
                          >> gdte_pkg::S_DATE_D1E4);
        q_time_d100 = 21'((64'(r_in.time_hhmmsscc) * gdte_pkg::M_TIME_D100)
                          >> gdte_pkg::S_TIME_D100);
        q_time_d1e4 = 14'((64'(r_in.time_hhmmsscc) * gdte_pkg::M_TIME_D1E4)
                          >> gdte_pkg::S_TIME_D1E4);
        n1_hour     = 8'((64'(r_in.time_hhmmsscc) * gdte_pkg::M_TIME_D1E6)
                          >> gdte_pkg::S_TIME_D1E6);
        n1_yy  = 7'(r_in.date_ddmmyy - (20'(q_date_d100) * 20'd100));
        n1_mon = 7'(q_date_d100 - (14'(n1_day) * 14'd100));
        n1_cc  = 7'(r_in.time_hhmmsscc - (27'(q_time_d100) * 27'd100));
        n1_sec = 7'(q_time_d100 - (21'(q_time_d1e4) * 21'd100));
        n1_min = 7'(q_time_d1e4 - (14'(n1_hour) * 14'd100));
    end

    always_comb begin
        n2_days = 17'(r1_yy) * 17'd365
                + 17'((8'(r1_yy) + 8'd3) >> 2)
                + 17'(gdte_pkg::days_before_month(r1_mon))
                + 17'((r1_mon > 7'd2) && (r1_yy[1:0] == 2'b00))
                + 17'(r1_day);
        n2_hms  = 19'(r1_hour) * 19'd3600 + 19'(r1_min) * 19'd60 + 19'(r1_sec);
    end

    always_comb begin
        n3_secs = gdte_pkg::SECS_BASE + 33'(r2_days) * gdte_pkg::SECS_PER_DAY
                + 33'(r2_hms);
    end

    always_comb begin
        n_out.month_invalid = r3_inv;
        if (r3_inv) begin
            n_out.epoch_ms = '0;
        end else begin
            n_out.epoch_ms = 42'(r3_secs) * gdte_pkg::MS_PER_SEC
                           + 42'(r3_cc) * 42'd10 + 42'(r3_dev);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_ready) r_v0 <= i_valid;
            if (rdy1)    r_v1 <= r_v0;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
            if (rdy4)    r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (rdy1 && r_v0) begin
            r1_yy   <= n1_yy;
            r1_mon  <= n1_mon;
            r1_day  <= n1_day;
            r1_hour <= n1_hour;
            r1_min  <= n1_min;
            r1_sec  <= n1_sec;
            r1_cc   <= n1_cc;
            r1_dev  <= r_in.clock_deviation_ms;
            r1_inv  <= (n1_mon == 7'd0) || (n1_mon > gdte_pkg::MONTHS);
        end
        if (rdy2 && r_v1) begin
            r2_days <= n2_days;
            r2_hms  <= n2_hms;
            r2_cc   <= r1_cc;
            r2_dev  <= r1_dev;
            r2_inv  <= r1_inv;
        end
        if (rdy3 && r_v2) begin
            r3_secs <= n3_secs;
            r3_cc   <= r2_cc;
            r3_dev  <= r2_dev;
            r3_inv  <= r2_inv;
        end
        if (rdy4 && r_v3) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
